/* hdl/pfd_pkg.sv */
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types and constants of the filtered-derivative PID core: register
// map, coefficient formats and reset values.
// ----------------------------------------------------------------------------
package pfd_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int ACC_WIDTH_DEF  = 32;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	localparam int GAIN_W  = 24;
	localparam int POLE_W  = 16;
	localparam int LIMIT_W = 15;
	localparam int INTV_W  = 32;

	localparam int ERR_FRAC  = 12;
	localparam int POLE_FRAC = 16;
	localparam int OUT_SHIFT = 4;

	localparam int USER_IN_W  = 2;
	localparam int USER_OUT_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DERIV_POLE    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_OUT_LIMIT     = 3'd4;

	localparam logic [GAIN_W-1:0]  RST_PROP_GAIN     = 24'd87732;
	localparam logic [GAIN_W-1:0]  RST_INTEGRAL_GAIN = 24'd439;
	localparam logic [POLE_W-1:0]  RST_DERIV_POLE    = 16'd0;
	localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN    = 24'd0;
	localparam logic [LIMIT_W-1:0] RST_OUT_LIMIT     = 15'd4096;

	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  integral_gain;
		logic [POLE_W-1:0]  deriv_pole;
		logic [GAIN_W-1:0]  deriv_gain;
		logic [LIMIT_W-1:0] out_limit;
	} cfg_t;

endpackage

/* hdl/pfd_cfg.sv */
// ----------------------------------------------------------------------------
// pfd_cfg
// Coefficient register file, written through a plain write port.
// ----------------------------------------------------------------------------
module pfd_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [pfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output pfd_pkg::cfg_t                    cfg
);

	pfd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= pfd_pkg::RST_PROP_GAIN;
			cfg_q.integral_gain <= pfd_pkg::RST_INTEGRAL_GAIN;
			cfg_q.deriv_pole    <= pfd_pkg::RST_DERIV_POLE;
			cfg_q.deriv_gain    <= pfd_pkg::RST_DERIV_GAIN;
			cfg_q.out_limit     <= pfd_pkg::RST_OUT_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				pfd_pkg::REG_PROP_GAIN: begin
					cfg_q.prop_gain <= cfg_data[pfd_pkg::GAIN_W-1:0];
				end
				pfd_pkg::REG_INTEGRAL_GAIN: begin
					cfg_q.integral_gain <= cfg_data[pfd_pkg::GAIN_W-1:0];
				end
				pfd_pkg::REG_DERIV_POLE: begin
					cfg_q.deriv_pole <= cfg_data[pfd_pkg::POLE_W-1:0];
				end
				pfd_pkg::REG_DERIV_GAIN: begin
					cfg_q.deriv_gain <= cfg_data[pfd_pkg::GAIN_W-1:0];
				end
				pfd_pkg::REG_OUT_LIMIT: begin
					cfg_q.out_limit <= cfg_data[pfd_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/pfd_step.sv */
// ----------------------------------------------------------------------------
// pfd_step
// One controller update: P, I and filtered D terms, accumulator saturation,
// output clamp and anti-windup decision.
// ----------------------------------------------------------------------------
module pfd_step #(
	parameter int DATA_WIDTH = pfd_pkg::DATA_WIDTH_DEF,
	parameter int ACC_WIDTH  = pfd_pkg::ACC_WIDTH_DEF
) (
	input  pfd_pkg::cfg_t                 cfg,
	input  logic signed [DATA_WIDTH-1:0]  error,
	input  logic                          blocked,
	input  logic                          clear,
	input  logic signed [ACC_WIDTH-1:0]   int_acc,
	input  logic signed [ACC_WIDTH-1:0]   der_acc,
	input  logic signed [DATA_WIDTH-1:0]  prev_err,
	output logic signed [ACC_WIDTH-1:0]   int_next,
	output logic signed [ACC_WIDTH-1:0]   der_next,
	output logic signed [DATA_WIDTH-1:0]  prev_next,
	output logic signed [DATA_WIDTH-1:0]  drive,
	output logic                          saturated
);

	localparam int GSW  = pfd_pkg::GAIN_W + 1;
	localparam int PW   = GSW + DATA_WIDTH;
	localparam int TW   = PW - pfd_pkg::ERR_FRAC;
	localparam int IW   = ((ACC_WIDTH > TW) ? ACC_WIDTH : TW) + 1;
	localparam int DFW  = DATA_WIDTH + 1;
	localparam int DPW  = GSW + DFW;
	localparam int DTW  = DPW - pfd_pkg::ERR_FRAC;
	localparam int QW   = pfd_pkg::POLE_W + 1 + ACC_WIDTH;
	localparam int QTW  = QW - pfd_pkg::POLE_FRAC;
	localparam int DSW  = ((QTW > DTW) ? QTW : DTW) + 1;
	localparam int SW   = ((ACC_WIDTH > TW) ? ACC_WIDTH : TW) + 2;
	localparam int UW   = SW - pfd_pkg::OUT_SHIFT;

	logic signed [GSW-1:0]       kp_s;
	logic signed [GSW-1:0]       ki_s;
	logic signed [GSW-1:0]       kd_s;
	logic signed [pfd_pkg::POLE_W:0] pole_s;
	logic signed [PW-1:0]        p_prod;
	logic signed [PW-1:0]        i_prod;
	logic signed [TW-1:0]        p_term;
	logic signed [TW-1:0]        i_inc;
	logic signed [IW-1:0]        i_sum;
	logic signed [ACC_WIDTH-1:0] i_new;
	logic signed [DFW-1:0]       e_diff;
	logic signed [DPW-1:0]       d_prod;
	logic signed [DTW-1:0]       d_inc;
	logic signed [QW-1:0]        q_prod;
	logic signed [QTW-1:0]       d_old;
	logic signed [DSW-1:0]       d_sum;
	logic signed [ACC_WIDTH-1:0] d_new;
	logic signed [SW-1:0]        total;
	logic signed [UW-1:0]        u;
	logic signed [UW-1:0]        lim;
	logic signed [UW-1:0]        dmax;
	logic signed [UW-1:0]        dmin;
	logic signed [UW-1:0]        c1;
	logic signed [UW-1:0]        c2;
	logic                        sat1;
	logic                        sat2;
	logic                        i_ovf;
	logic                        d_ovf;

	localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	always_comb begin
		kp_s   = signed'({1'b0, cfg.prop_gain});
		ki_s   = signed'({1'b0, cfg.integral_gain});
		kd_s   = signed'({1'b0, cfg.deriv_gain});
		pole_s = signed'({1'b0, cfg.deriv_pole});

		p_prod = PW'(kp_s) * PW'(error);
		i_prod = PW'(ki_s) * PW'(error);
		p_term = p_prod[PW-1:pfd_pkg::ERR_FRAC];
		i_inc  = i_prod[PW-1:pfd_pkg::ERR_FRAC];

		i_sum = IW'(int_acc) + IW'(i_inc);
		i_ovf = !((&i_sum[IW-1:ACC_WIDTH-1]) || !(|i_sum[IW-1:ACC_WIDTH-1]));
		i_new = i_ovf ? (i_sum[IW-1] ? ACC_MIN : ACC_MAX) : i_sum[ACC_WIDTH-1:0];

		e_diff = DFW'(error) - DFW'(prev_err);
		d_prod = DPW'(kd_s) * DPW'(e_diff);
		d_inc  = d_prod[DPW-1:pfd_pkg::ERR_FRAC];
		q_prod = QW'(pole_s) * QW'(der_acc);
		d_old  = q_prod[QW-1:pfd_pkg::POLE_FRAC];

		d_sum = DSW'(d_old) + DSW'(d_inc);
		d_ovf = !((&d_sum[DSW-1:ACC_WIDTH-1]) || !(|d_sum[DSW-1:ACC_WIDTH-1]));
		d_new = d_ovf ? (d_sum[DSW-1] ? ACC_MIN : ACC_MAX) : d_sum[ACC_WIDTH-1:0];

		total = SW'(p_term) + SW'(i_new) + SW'(d_new);
		u     = total[SW-1:pfd_pkg::OUT_SHIFT];

		lim  = UW'(signed'({1'b0, cfg.out_limit}));
		dmax = UW'(signed'({1'b0, {(DATA_WIDTH-1){1'b1}}}));
		dmin = ~dmax;

		if (u > lim) begin
			c1   = lim;
			sat1 = 1'b1;
		end else if (u < -lim) begin
			c1   = -lim;
			sat1 = 1'b1;
		end else begin
			c1   = u;
			sat1 = 1'b0;
		end

		if (c1 > dmax) begin
			c2   = dmax;
			sat2 = 1'b1;
		end else if (c1 < dmin) begin
			c2   = dmin;
			sat2 = 1'b1;
		end else begin
			c2   = c1;
			sat2 = 1'b0;
		end

		if (clear) begin
			int_next  = '0;
			der_next  = '0;
			prev_next = '0;
			drive     = '0;
			saturated = 1'b0;
		end else begin
			int_next  = (sat1 || sat2 || blocked) ? '0 : i_new;
			der_next  = d_new;
			prev_next = error;
			drive     = c2[DATA_WIDTH-1:0];
			saturated = sat1 || sat2;
		end
	end

endmodule

/* hdl/pid_filtered_derivative_core.sv */
// ----------------------------------------------------------------------------
// pid_filtered_derivative_core
// Discrete PID controller with first-order filtered derivative, output clamp
// and integral clearing on saturation or blocked actuator.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+---------------------------------
//   s_*      | in  | s_tvalid / s_tready | tdata: error; tuser: blocked, clear
//   m_*      | out | m_tvalid / m_tready | tdata: drive, integral_value;
//            |     |                     | tuser: saturated
//   cfg_*    | in  | cfg_we              | cfg_index, cfg_data
//
// One beat per cycle sustained while m_tready holds. A beat is captured in the
// input register, then in the result register that drives m_*; the whole update
// (four multiplies, sums, clamp) sits between the input and result registers.
// Reset zeroes the controller state and loads the default coefficients.
// A stalled output register holds the input register and the state.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_core #(
	parameter int DATA_WIDTH = pfd_pkg::DATA_WIDTH_DEF,
	parameter int ACC_WIDTH  = pfd_pkg::ACC_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// [DATA_WIDTH-1:0] error
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]         s_tdata,
	// [0] blocked, [1] clear
	input  logic [pfd_pkg::USER_IN_W-1:0]           s_tuser,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// [DATA_WIDTH-1:0] drive, [DATA_WIDTH+31:DATA_WIDTH] integral_value
	output logic [((DATA_WIDTH+pfd_pkg::INTV_W+7)/8)*8-1:0] m_tdata,
	// [0] saturated
	output logic [pfd_pkg::USER_OUT_W-1:0]          m_tuser,
	input  logic                                    cfg_we,
	input  logic [pfd_pkg::CFG_INDEX_W-1:0]         cfg_index,
	input  logic [pfd_pkg::CFG_DATA_W-1:0]          cfg_data
);

	localparam int M_DATA_W = ((DATA_WIDTH + pfd_pkg::INTV_W + 7) / 8) * 8;
	localparam int EXT_W    = (ACC_WIDTH > pfd_pkg::INTV_W) ? ACC_WIDTH : pfd_pkg::INTV_W;

	pfd_pkg::cfg_t cfg;

	logic                         valid_s1;
	logic signed [DATA_WIDTH-1:0] error_s1;
	logic                         blocked_s1;
	logic                         clear_s1;

	logic signed [ACC_WIDTH-1:0]  int_acc_q;
	logic signed [ACC_WIDTH-1:0]  der_acc_q;
	logic signed [DATA_WIDTH-1:0] prev_err_q;

	logic signed [ACC_WIDTH-1:0]  int_next;
	logic signed [ACC_WIDTH-1:0]  der_next;
	logic signed [DATA_WIDTH-1:0] prev_next;
	logic signed [DATA_WIDTH-1:0] drive;
	logic                         saturated;
	logic signed [EXT_W-1:0]      int_ext;

	logic advance;
	logic fire;
	logic s_take;

	pfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pfd_step #(
		.DATA_WIDTH (DATA_WIDTH),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_step (
		.cfg       (cfg),
		.error     (error_s1),
		.blocked   (blocked_s1),
		.clear     (clear_s1),
		.int_acc   (int_acc_q),
		.der_acc   (der_acc_q),
		.prev_err  (prev_err_q),
		.int_next  (int_next),
		.der_next  (der_next),
		.prev_next (prev_next),
		.drive     (drive),
		.saturated (saturated)
	);

	assign advance  = !m_tvalid || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign s_take   = s_tvalid && s_tready;
	assign int_ext  = EXT_W'(int_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			error_s1   <= s_tdata[DATA_WIDTH-1:0];
			blocked_s1 <= s_tuser[0];
			clear_s1   <= s_tuser[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_acc_q  <= '0;
			der_acc_q  <= '0;
			prev_err_q <= '0;
		end else if (fire) begin
			int_acc_q  <= int_next;
			der_acc_q  <= der_next;
			prev_err_q <= prev_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata <= M_DATA_W'({int_ext[pfd_pkg::INTV_W-1:0], drive});
			m_tuser <= pfd_pkg::USER_OUT_W'(saturated);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && clear_s1) |=> (m_tdata == '0 && m_tuser == '0))
		else $error("clear beat did not give a zero result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[DATA_WIDTH+pfd_pkg::INTV_W-1:DATA_WIDTH] == '0))
		else $error("integral kept through a saturated beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> ($stable(int_acc_q) && $stable(der_acc_q)
			&& $stable(prev_err_q)))
		else $error("controller state moved while the output stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (m_tdata[DATA_WIDTH+pfd_pkg::INTV_W-1:DATA_WIDTH]
			== $past(int_ext[pfd_pkg::INTV_W-1:0])))
		else $error("integral field does not match the stored integral");

endmodule
